@@ design/stred_pkg.sv @@
// Shared types and constants for the strided tensor reduction block.
// Used by stred_front, stred_back and the top level; depends on nothing else.
package stred_pkg;

  localparam int MAX_INNER_DEF = 256;
  localparam int ACC_WIDTH_DEF = 48;

  localparam int SAMPLE_W   = 32;
  localparam int INDEX_W    = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int STRIDE_W   = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  // Reduction modes; codes five to seven fall back to sum.
  localparam logic [2:0] MODE_SUM    = 3'd0;
  localparam logic [2:0] MODE_MEAN   = 3'd1;
  localparam logic [2:0] MODE_MIN    = 3'd2;
  localparam logic [2:0] MODE_MAX    = 3'd3;
  localparam logic [2:0] MODE_ARGMAX = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_SCALE = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] reduce_len;
    logic [8:0]  inner_stride;
    logic [16:0] mean_scale;
  } cfg_t;

  // One classified element as it travels from the front end to the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         rpos;
    logic                       first;
    logic                       emit;
    logic                       last;
  } item_meta_t;

  localparam int META_W = $bits(item_meta_t);

  typedef struct packed {
    logic               last;
    logic [INDEX_W-1:0] index;
    logic [31:0]        value;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

@@ design/stred_queue.sv @@
// Small register FIFO used as the hand-off queue and as the result buffer.
// Depends on nothing; width and depth come from the instantiating module.
module stred_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [WIDTH-1:0]           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [WIDTH-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             push;
  logic             pop;

  assign in_ready  = count < CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign head_data = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ design/stred_front.sv @@
// Front end: tracks inner and reduce positions and classifies each element.
// Depends on stred_pkg for the configuration and item types.
module stred_front #(
  parameter int MAX_INNER = 256,
  parameter int ADDR_W    = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stred_pkg::cfg_t          cfg,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,
  input  logic                     s_axis_tlast,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [ADDR_W-1:0]        push_addr,
  output stred_pkg::item_meta_t    push_meta
);
  import stred_pkg::*;

  localparam int CW = (ADDR_W + 1 > STRIDE_W) ? ADDR_W + 1 : STRIDE_W;

  logic [ADDR_W-1:0] inner_pos;
  logic [ADDR_W-1:0] inner_pos_next;
  logic [15:0]       reduce_pos;
  logic [15:0]       reduce_pos_next;
  logic [CW-1:0]     stride_eff;
  logic [CW-1:0]     ip_inc;
  logic [15:0]       rlen_eff;
  logic [16:0]       rp_inc;
  logic              accept;

  assign s_axis_tready = push_ready;
  assign push_valid    = s_axis_tvalid;
  assign accept        = s_axis_tvalid && push_ready;

  always_comb begin
    stride_eff = (cfg.inner_stride == '0) ? CW'(1) : CW'(cfg.inner_stride);
    if (stride_eff > CW'(MAX_INNER)) begin
      stride_eff = CW'(MAX_INNER);
    end
    rlen_eff = (cfg.reduce_len == '0) ? 16'd1 : cfg.reduce_len;
    ip_inc   = CW'(inner_pos) + CW'(1);
    rp_inc   = {1'b0, reduce_pos} + 17'd1;

    inner_pos_next  = inner_pos;
    reduce_pos_next = reduce_pos;
    if (accept) begin
      if (s_axis_tlast) begin
        inner_pos_next  = '0;
        reduce_pos_next = '0;
      end else if (ip_inc >= stride_eff) begin
        // End of a slice: step along the reduced axis.
        inner_pos_next  = '0;
        reduce_pos_next = (rp_inc >= {1'b0, rlen_eff}) ? '0 : rp_inc[15:0];
      end else begin
        inner_pos_next = ip_inc[ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    push_addr        = inner_pos;
    push_meta.sample = s_axis_tdata;
    push_meta.rpos   = reduce_pos;
    push_meta.first  = reduce_pos == '0;
    push_meta.emit   = reduce_pos == (rlen_eff - 16'd1);
    push_meta.last   = s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_pos  <= '0;
      reduce_pos <= '0;
    end else begin
      inner_pos  <= inner_pos_next;
      reduce_pos <= reduce_pos_next;
    end
  end

endmodule

@@ design/stred_back.sv @@
// Back end: read-modify-write of the partial store, result formatting and
// the result buffer. Depends on stred_pkg and stred_queue.
module stred_back #(
  parameter int MAX_INNER = 256,
  parameter int ACC_WIDTH = 48,
  parameter int ADDR_W    = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stred_pkg::cfg_t       cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [ADDR_W-1:0]     q_addr,
  input  stred_pkg::item_meta_t q_meta,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,
  output logic                  m_axis_tlast
);
  import stred_pkg::*;

  localparam int ENTRY_W = ACC_WIDTH + INDEX_W;
  localparam int AW1     = ACC_WIDTH + 1;
  localparam int MW      = (ACC_WIDTH > 48) ? ACC_WIDTH : 48;
  localparam int OCNT_W  = $clog2(OUT_DEPTH + 1);

  logic [ENTRY_W-1:0] store [MAX_INNER];
  logic [ENTRY_W-1:0] rd_entry;

  logic               pop;
  logic [OCNT_W-1:0]  out_count;
  logic [OCNT_W-1:0]  inflight;
  logic [OCNT_W:0]    credit_used;
  logic               out_in_ready;

  // Read-modify-write stage
  logic               b_valid;
  logic [ADDR_W-1:0]  b_addr;
  item_meta_t         b_meta;
  logic               fw_valid;
  logic [ADDR_W-1:0]  fw_addr;
  logic [ENTRY_W-1:0] fw_entry;
  logic [ENTRY_W-1:0] old_entry;
  logic signed [ACC_WIDTH-1:0] old_p;
  logic [INDEX_W-1:0]          old_i;
  logic signed [ACC_WIDTH-1:0] s_ext;
  logic signed [AW1-1:0]       sum_w;
  logic signed [ACC_WIDTH-1:0] sum_sat;
  logic signed [ACC_WIDTH-1:0] acc_min;
  logic signed [ACC_WIDTH-1:0] new_p;
  logic [INDEX_W-1:0]          new_i;
  logic                        is_ext;

  // Formatting stages
  logic                        c_valid;
  logic signed [ACC_WIDTH-1:0] c_part;
  logic [INDEX_W-1:0]          c_idx;
  logic                        c_last;
  logic                        c_mean;
  logic                        c_neg;
  logic [ACC_WIDTH-1:0]        c_mag;
  logic [MW-1:0]               c_magx;
  logic [47:0]                 c_mag48;
  logic [31:0]                 c_sat;

  logic                 d_valid;
  logic                 d_mean;
  logic                 d_neg;
  logic [47:0]          d_mag;
  logic [31:0]          d_sat;
  logic [INDEX_W-1:0]   d_idx;
  logic                 d_last;
  logic [48:0]          d_hi;
  logic [32:0]          d_lo;

  logic                 e_valid;
  logic                 e_mean;
  logic                 e_neg;
  logic [48:0]          e_hi;
  logic [32:0]          e_lo;
  logic [31:0]          e_sat;
  logic [INDEX_W-1:0]   e_idx;
  logic                 e_last;
  logic [33:0]          e_lo_rnd;
  logic [49:0]          e_q;
  logic [31:0]          e_mean_val;
  result_t              e_res;
  result_t              out_res;

  // Issue from the queue only when the result buffer has room for every
  // emitting element already in flight.
  assign credit_used = {1'b0, out_count} + {1'b0, inflight};
  assign q_ready     = credit_used < (OCNT_W + 1)'(OUT_DEPTH);
  assign pop         = q_valid && q_ready;

  always_ff @(posedge clk) begin
    rd_entry <= store[q_addr];
    if (b_valid) begin
      store[b_addr] <= {new_p, new_i};
    end
  end

  // The entry written in the previous cycle is not yet visible in rd_entry.
  always_comb begin
    old_entry = (fw_valid && fw_addr == b_addr) ? fw_entry : rd_entry;
    old_p     = old_entry[ENTRY_W-1:INDEX_W];
    old_i     = old_entry[INDEX_W-1:0];
    s_ext     = ACC_WIDTH'(b_meta.sample);
    acc_min   = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
    sum_w     = AW1'(old_p) + AW1'(s_ext);
    if (sum_w[AW1-1] != sum_w[AW1-2]) begin
      sum_sat = sum_w[AW1-1] ? acc_min : ~acc_min;
    end else begin
      sum_sat = sum_w[ACC_WIDTH-1:0];
    end

    is_ext = 1'b0;
    new_p  = old_p;
    new_i  = old_i;
    case (cfg.mode)
      MODE_MIN: begin
        is_ext = 1'b1;
        if (s_ext < old_p) begin
          new_p = s_ext;
          new_i = b_meta.rpos;
        end
      end
      MODE_MAX, MODE_ARGMAX: begin
        is_ext = 1'b1;
        if (s_ext > old_p) begin
          new_p = s_ext;
          new_i = b_meta.rpos;
        end
      end
      default: begin
        new_p = sum_sat;
      end
    endcase
    if (b_meta.first) begin
      new_p = s_ext;
      new_i = '0;
    end
  end

  always_comb begin
    c_neg  = c_part[ACC_WIDTH-1];
    c_mag  = c_neg ? -c_part : c_part;
    c_magx = MW'(c_mag);
    if (c_magx > MW'(48'h8000_0000_0000)) begin
      c_magx = MW'(48'h8000_0000_0000);
    end
    c_mag48 = c_magx[47:0];
    if ((&c_part[ACC_WIDTH-1:31]) || !(|c_part[ACC_WIDTH-1:31])) begin
      c_sat = c_part[31:0];
    end else begin
      c_sat = c_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  assign d_hi = 49'(d_mag[47:16]) * 49'(cfg.mean_scale);
  assign d_lo = 33'(d_mag[15:0]) * 33'(cfg.mean_scale);

  always_comb begin
    e_lo_rnd = 34'(e_lo) + 34'h8000;
    e_q      = 50'(e_hi) + 50'(e_lo_rnd[33:16]);
    if (e_q >= 50'h8000_0000) begin
      e_mean_val = e_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      e_mean_val = e_neg ? -e_q[31:0] : e_q[31:0];
    end
    e_res.value = e_mean ? e_mean_val : e_sat;
    e_res.index = e_idx;
    e_res.last  = e_last;
  end

  always_ff @(posedge clk) begin
    b_addr   <= q_addr;
    b_meta   <= q_meta;
    fw_addr  <= b_addr;
    fw_entry <= {new_p, new_i};
    c_part   <= new_p;
    c_idx    <= is_ext ? new_i : '0;
    c_last   <= b_meta.last;
    c_mean   <= cfg.mode == MODE_MEAN;
    d_mean   <= c_mean;
    d_neg    <= c_neg;
    d_mag    <= c_mag48;
    d_sat    <= c_sat;
    d_idx    <= c_idx;
    d_last   <= c_last;
    e_mean   <= d_mean;
    e_neg    <= d_neg;
    e_hi     <= d_hi;
    e_lo     <= d_lo;
    e_sat    <= d_sat;
    e_idx    <= d_idx;
    e_last   <= d_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      fw_valid <= 1'b0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
      e_valid  <= 1'b0;
      inflight <= '0;
    end else begin
      b_valid  <= pop;
      fw_valid <= b_valid;
      c_valid  <= b_valid && b_meta.emit;
      d_valid  <= c_valid;
      e_valid  <= d_valid;
      if ((pop && q_meta.emit) && !e_valid) begin
        inflight <= inflight + OCNT_W'(1);
      end else if (!(pop && q_meta.emit) && e_valid) begin
        inflight <= inflight - OCNT_W'(1);
      end
    end
  end

  stred_queue #(
    .WIDTH (RESULT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_valid),
    .in_ready  (out_in_ready),
    .in_data   (e_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .head_data (out_res),
    .count     (out_count)
  );

  assign m_axis_tdata = {out_res.index, out_res.value};
  assign m_axis_tlast = out_res.last;

  a_no_buffer_overrun: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> out_in_ready)
    else $error("result pushed into a full output buffer");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_used <= (OCNT_W + 1)'(OUT_DEPTH))
    else $error("results in flight exceed output buffer space");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> $past(b_valid && b_meta.emit, 3))
    else $error("result appeared without an emitting element");

endmodule

@@ design/strided_tensor_reduce.sv @@
// Top level of the strided tensor reduction block: configuration registers,
// front end, hand-off queue and back end. Depends on stred_pkg, stred_front,
// stred_queue and stred_back.
//
//  Channel   Signals                                 Payload
//  s_axis    tvalid tready tdata[31:0] tlast        sample ; tensor_last
//  m_axis    tvalid tready tdata[47:0] tlast        result_value, result_index ; result_last
//  cfg       cfg_we cfg_index[1:0] cfg_data[16:0]   0 mode, 1 reduce_len, 2 inner_stride,
//                                                    3 mean_scale
//
// One element is taken every cycle while the queue has room; the partial store
// is a single-port-write, registered-read memory updated once per element, with
// bypass of the previous write. Results are formatted into the result buffer.
// Reset is synchronous and clears counters and pipeline valids; the partial
// store is not cleared, since every entry is seeded by the first slice.
// Each side may stall freely: the queue and the result buffer absorb it.
module strided_tensor_reduce #(
  parameter int MAX_INNER = stred_pkg::MAX_INNER_DEF,
  parameter int ACC_WIDTH = stred_pkg::ACC_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,   // [31:0] sample
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata,   // [31:0] result_value, [47:32] result_index
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [stred_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stred_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stred_pkg::*;

  localparam int ADDR_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int QW     = ADDR_W + META_W;

  cfg_t              cfg;
  logic              push_valid;
  logic              push_ready;
  logic [ADDR_W-1:0] push_addr;
  item_meta_t        push_meta;
  logic              q_valid;
  logic              q_ready;
  logic [QW-1:0]     q_data;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  logic              q_spare;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_SUM;
      cfg.reduce_len   <= 16'd1;
      cfg.inner_stride <= 9'd1;
      cfg.mean_scale   <= 17'h10000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:       cfg.mode         <= cfg_data[2:0];
        CFG_REDUCE_LEN: cfg.reduce_len   <= cfg_data[15:0];
        CFG_STRIDE:     cfg.inner_stride <= cfg_data[8:0];
        CFG_MEAN_SCALE: cfg.mean_scale   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  stred_front #(
    .MAX_INNER (MAX_INNER),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_addr     (push_addr),
    .push_meta     (push_meta)
  );

  stred_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   ({push_addr, push_meta}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .head_data (q_data),
    .count     (q_count)
  );

  // The queue occupancy is only observed here for the empty/valid cross-check.
  assign q_spare = (q_count == '0) == !q_valid;

  stred_back #(
    .MAX_INNER (MAX_INNER),
    .ACC_WIDTH (ACC_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_addr        (q_data[QW-1:META_W]),
    .q_meta        (q_data[META_W-1:0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_queue_count: assert property (@(posedge clk) disable iff (rst) q_spare)
    else $error("queue occupancy disagrees with its valid flag");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    !push_ready |-> q_valid)
    else $error("queue reports full while empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

endmodule

@@ verif/tb_strided_tensor_reduce.sv @@
// Self-checking testbench for strided_tensor_reduce: a directed table followed by random
// phases, every result predicted in the bench and compared in order of arrival.
// Depends on stred_pkg and the design under design/.
`timescale 1ns / 100ps

module tb_strided_tensor_reduce;
  import stred_pkg::*;

  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int RANDOM_ITEMS = 1550;
  localparam int LONG_AXIS = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] sample
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [31:0] result_value, [47:32] result_index
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  strided_tensor_reduce dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bench copy of the configuration, with the effective length and stride.
  logic [2:0]  reg_mode = MODE_SUM;
  logic [16:0] reg_scale = 17'd65536;
  int          span_len = 1;
  int          span_stride = 1;

  // Bench copy of the per-position partials and the position counters.
  longint      part_acc [MAX_INNER_DEF];
  logic [15:0] part_best [MAX_INNER_DEF];
  logic [7:0]  pos_inner = '0;
  logic [15:0] pos_slice = '0;

  result_t pending_results[$];
  int      mismatches = 0;
  int      fed = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;

  typedef struct {
    bit          setup;
    logic [2:0]  mode;
    logic [15:0] len;
    logic [8:0]  stride;
    logic [16:0] scale;
    logic [31:0] data;
    logic        last;
    bit          typed;
    result_t     want;
  } plan_row_t;

  plan_row_t plan[$];

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Folds one element into its partial and returns 1 when it finishes a result.
  function automatic bit fold_element(input logic [31:0] d, input logic l, output result_t r);
    longint s, acc, v, hi, lo;
    longint unsigned mag, q, f;
    int ip, rp;
    bit neg, emit;
    logic [15:0] idx;
    s = longint'($signed(d));
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -hi - 1;
    ip = int'(pos_inner);
    rp = int'(pos_slice);
    acc = part_acc[ip];
    if (rp == 0) begin
      acc = s;
      part_best[ip] = '0;
    end else if (reg_mode == MODE_MIN) begin
      if (s < acc) begin
        acc = s;
        part_best[ip] = 16'(rp);
      end
    end else if (reg_mode == MODE_MAX || reg_mode == MODE_ARGMAX) begin
      if (s > acc) begin
        acc = s;
        part_best[ip] = 16'(rp);
      end
    end else if (s > 0 && acc > hi - s) begin
      acc = hi;
    end else if (s < 0 && acc < lo - s) begin
      acc = lo;
    end else begin
      acc = acc + s;
    end
    part_acc[ip] = acc;

    emit = (rp == span_len - 1);
    r = '0;
    if (emit) begin
      idx = '0;
      if (reg_mode == MODE_MIN || reg_mode == MODE_MAX || reg_mode == MODE_ARGMAX) begin
        v = clip32(acc);
        idx = part_best[ip];
      end else if (reg_mode == MODE_MEAN) begin
        // Magnitude times the Q1.16 factor, halves rounded away from zero.
        neg = (acc < 0);
        mag = neg ? -acc : acc;
        f = reg_scale;
        if (f == 0) begin
          v = 0;
        end else begin
          if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
          q = (mag >> 16) * f + (((mag & 64'hFFFF) * f + 64'h8000) >> 16);
          if (q > 64'h8000_0000) q = 64'h8000_0000;
          v = clip32(neg ? -longint'(q) : longint'(q));
        end
      end else begin
        v = clip32(acc);
      end
      r.value = v[31:0];
      r.index = idx;
      r.last = l;
    end

    if (l) begin
      pos_inner = '0;
      pos_slice = '0;
    end else begin
      ip = ip + 1;
      if (ip >= span_stride) begin
        ip = 0;
        rp = rp + 1;
        if (rp >= span_len) rp = 0;
      end
      pos_inner = 8'(ip);
      pos_slice = 16'(rp);
    end
    return emit;
  endfunction

  function automatic logic [31:0] pick_sample();
    int step;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      // A narrow set of values, so that ties along the axis are common.
      1, 2, 3: begin
        step = $urandom_range(0, 6);
        return 32'((step - 3) <<< 16);
      end
      default: return $urandom;
    endcase
  endfunction

  // Offers one element, waits for the transaction and records what it should produce.
  task automatic push_element(input logic [31:0] d, input logic l, input bit typed,
                              input result_t want);
    result_t r;
    bit emit;
    while (!calm && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
    emit = fold_element(d, l, r);
    if (typed) pending_results.push_back(want);
    else if (emit) pending_results.push_back(r);
  endtask

  // Lets every outstanding result come back, then gives the pipeline time to empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setup(input logic [2:0] md, input logic [15:0] len,
                             input logic [8:0] st, input logic [16:0] sc);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data <= CFG_DATA_W'(md);
    @(posedge clk);
    cfg_index <= CFG_REDUCE_LEN;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= CFG_STRIDE;
    cfg_data <= CFG_DATA_W'(st);
    @(posedge clk);
    cfg_index <= CFG_MEAN_SCALE;
    cfg_data <= sc;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_mode = md;
    reg_scale = sc;
    span_len = (len == 0) ? 1 : int'(len);
    span_stride = (st == 0) ? 1 : int'(st);
    if (span_stride > MAX_INNER_DEF) span_stride = MAX_INNER_DEF;
  endtask

  // One tensor under the current setup; a broken one may end early on tensor_last.
  task automatic stream_tensor(input bit broken, input int reps);
    int full, count;
    full = span_len * span_stride * reps;
    count = broken ? $urandom_range(1, full) : full;
    for (int k = 0; k < count; k++) push_element(pick_sample(), k == count - 1, 1'b0, '0);
    fed += count;
  endtask

  // One random setup and a few tensors under it, stopping early once the goal is reached.
  task automatic random_phase(input int goal);
    logic [2:0]  md;
    logic [15:0] len;
    logic [8:0]  st;
    logic [16:0] sc;
    int          tensors;
    case ($urandom_range(0, 9))
      0: md = MODE_SUM;
      1, 2: md = MODE_MEAN;
      3, 4: md = MODE_MIN;
      5, 6: md = MODE_MAX;
      7, 8: md = MODE_ARGMAX;
      default: begin
        case ($urandom_range(0, 2))
          0: md = MODE_RSVD5;
          1: md = MODE_RSVD6;
          default: md = MODE_RSVD7;
        endcase
      end
    endcase
    case ($urandom_range(0, 9))
      0: len = '0;
      1, 2: len = 16'($urandom_range(7, 24));
      default: len = 16'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: st = '0;
      1, 2: st = 9'($urandom_range(5, 12));
      default: st = 9'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 4))
      0: sc = '0;
      1: sc = 17'd65536;
      2: sc = 17'($urandom_range(0, 131071));
      default: sc = 17'((65536 + int'(len) / 2) / ((len == 0) ? 1 : int'(len)));
    endcase
    apply_setup(md, len, st, sc);
    tensors = $urandom_range(1, 4);
    do begin
      stream_tensor($urandom_range(0, 99) < 15, ($urandom_range(0, 3) == 0) ? 2 : 1);
      tensors--;
    end while (tensors > 0 && fed < goal);
  endtask

  function automatic void plan_setup(input logic [2:0] md, input logic [15:0] len,
                                     input logic [8:0] st, input logic [16:0] sc);
    plan_row_t row;
    row = '{default: '0};
    row.setup = 1'b1;
    row.mode = md;
    row.len = len;
    row.stride = st;
    row.scale = sc;
    plan.push_back(row);
  endfunction

  function automatic void plan_elem(input logic [31:0] d, input logic l);
    plan_row_t row;
    row = '{default: '0};
    row.data = d;
    row.last = l;
    plan.push_back(row);
  endfunction

  function automatic void plan_known(input logic [31:0] d, input logic l,
                                     input logic [31:0] value, input logic [15:0] index);
    plan_row_t row;
    row = '{default: '0};
    row.data = d;
    row.last = l;
    row.typed = 1'b1;
    row.want.value = value;
    row.want.index = index;
    row.want.last = l;
    plan.push_back(row);
  endfunction

  initial begin : result_side
    int hold_left;
    bit hold_taken;
    result_t got, want;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[31:0];
        got.index = m_axis_tdata[47:32];
        got.last = m_axis_tlast;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: value %h index %0d last %0b",
                                  got.value, got.index, got.last));
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value)
            note_mismatch($sformatf("result_value %h, expected %h", got.value, want.value));
          if (got.index !== want.index)
            note_mismatch($sformatf("result_index %0d, expected %0d", got.index, want.index));
          if (got.last !== want.last)
            note_mismatch($sformatf("result_last %0b, expected %0b", got.last, want.last));
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[strided_tensor_reduce] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] spare;
    int calm_base;

    // Reset values: sum over a length of one, so every element comes straight back.
    plan_known(32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 16'd0);
    plan_known(32'h8000_0000, 1'b0, 32'h8000_0000, 16'd0);
    plan_known(32'h0000_0000, 1'b1, 32'h0000_0000, 16'd0);
    plan_known(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 16'd0);
    plan_known(32'h0001_0000, 1'b1, 32'h0001_0000, 16'd0);
    // A mode code without meaning behaves as sum; both saturation limits.
    plan_setup(MODE_RSVD7, 16'd2, 9'd1, 17'd65536);
    plan_elem(32'h7FFF_FFFF, 1'b0);
    plan_elem(32'h7FFF_FFFF, 1'b0);
    plan_elem(32'h8000_0000, 1'b0);
    plan_elem(32'h8000_0000, 1'b1);
    // Mean by one half: halves round away from zero on both signs.
    plan_setup(MODE_MEAN, 16'd2, 9'd1, 17'd32768);
    plan_elem(32'h0000_0001, 1'b0);
    plan_elem(32'h0000_0002, 1'b0);
    plan_elem(32'hFFFF_FFFF, 1'b0);
    plan_elem(32'hFFFF_FFFE, 1'b1);
    // Zero length and zero stride both act as one.
    plan_setup(MODE_MIN, 16'd0, 9'd0, 17'd65536);
    plan_known(32'h8000_0000, 1'b1, 32'h8000_0000, 16'd0);
    // Argmax over a strided axis; a tie keeps the first position.
    plan_setup(MODE_ARGMAX, 16'd3, 9'd2, 17'd65536);
    plan_elem(32'h0005_0000, 1'b0);
    plan_elem(32'h0007_0000, 1'b0);
    plan_elem(32'h0005_0000, 1'b0);
    plan_elem(32'h0009_0000, 1'b0);
    plan_elem(32'h0002_0000, 1'b0);
    plan_elem(32'h0009_0000, 1'b1);
    // An early tensor_last yields nothing and restarts the counters.
    plan_setup(MODE_MAX, 16'd3, 9'd1, 17'd65536);
    plan_elem(32'h0001_0000, 1'b0);
    plan_elem(32'h0002_0000, 1'b1);
    plan_elem(32'h8000_0000, 1'b0);
    plan_elem(32'h8000_0000, 1'b0);
    plan_elem(32'h7FFF_FFFF, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].setup) begin
        apply_setup(plan[i].mode, plan[i].len, plan[i].stride, plan[i].scale);
      end else begin
        push_element(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    // One result per element while the receiver holds off, so the block backs up.
    apply_setup(MODE_SUM, 16'd1, 9'd1, 17'd65536);
    hold_req = 1'b1;
    for (int k = 0; k < 150; k++)
      push_element(pick_sample(), k == 149 || $urandom_range(0, 15) == 0, 1'b0, '0);
    fed += 150;

    // A stretch with neither side idling.
    calm = 1'b1;
    calm_base = fed;
    while (fed - calm_base < 300) random_phase(calm_base + 300);
    calm = 1'b0;

    // Strides at and beyond the store depth, which clamp to it.
    apply_setup($urandom_range(0, 1) ? MODE_MAX : MODE_MIN, 16'd2,
                9'($urandom_range(256, 511)), 17'd65536);
    stream_tensor(1'b0, 1);

    while (fed < RANDOM_ITEMS - LONG_AXIS) random_phase(RANDOM_ITEMS - LONG_AXIS);

    // A long axis, with its maximum on the final element.
    apply_setup(MODE_ARGMAX, 16'(LONG_AXIS), 9'd1, 17'd65536);
    for (int k = 0; k < LONG_AXIS; k++) begin
      spare = $urandom;
      if (k == LONG_AXIS - 1) spare = 32'h7FFF_FFFF;
      else if (spare == 32'h7FFF_FFFF) spare = '0;
      push_element(spare, k == LONG_AXIS - 1, 1'b0, '0);
    end
    fed += LONG_AXIS;

    settle();
    if (mismatches == 0) begin
      $display("[strided_tensor_reduce] OK");
    end else begin
      $display("[strided_tensor_reduce] ERROR");
    end
    $finish;
  end

endmodule
